// ----- hw/rtl/text_console_scrollback_unit_macros.svh -----
// Assertion macros used by the checker of the console block.
`ifndef TEXT_CONSOLE_SCROLLBACK_UNIT_MACROS_SVH
`define TEXT_CONSOLE_SCROLLBACK_UNIT_MACROS_SVH

// Same-cycle implication, disabled while rst_n is low.
`define TCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rst_n is low.
`define TCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tcs_pkg.sv -----
package tcs_pkg;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] BS_CHAR    = 8'h08;
    localparam logic [7:0] TAB_CHAR   = 8'h09;
    localparam logic [7:0] NL_CHAR    = 8'h0A;
    localparam logic [7:0] ATTR_RESET = 8'h0F;

    // Register index as decoded from paddr[2].
    localparam logic REG_IDX_TEXT  = 1'b0;
    localparam logic REG_IDX_BLANK = 1'b1;

    typedef enum logic [2:0] {
        KIND_PUT   = 3'd0,
        KIND_UP    = 3'd1,
        KIND_DOWN  = 3'd2,
        KIND_CLEAR = 3'd3,
        KIND_READ  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT,
        ST_FILL,
        ST_DIV,
        ST_MAP,
        ST_MEM,
        ST_DATA,
        ST_RESULT
    } t_state;

endpackage

// ----- hw/rtl/text_console_scrollback_unit.sv -----
// Text console cell store with scrollback.
// Requests enter on the s_axis channel: tuser carries the kind (put character,
// view up, view down, clear all, read screen cell), tdata the character and
// the screen cell index. Every request gives exactly one result on m_axis:
// the read cell value, the cursor offset relative to the view and the first
// line shown. The user must set attributes through the APB port only while
// the block is idle; the block itself does not enforce this. The block takes
// one request at a time. View moves, ignored characters and reads past the
// viewport go straight to the result; a put writes its cells one by one (up
// to SCREEN_COLUMNS for a newline) and blanks SCREEN_COLUMNS cells for a new
// last line each time the last line is reached and the oldest one is dropped.
// A read steps through the screen rows one by one, then address, memory
// access and data, or skips the memory access and gives a blank cell when
// the row lies past the end of the store. Clear all sweeps the whole store,
// BUFFER_ROWS * SCREEN_COLUMNS cells (5120 by default).
// After reset the same sweep blanks the store with attribute 0x0F, and no
// request is taken until it ends; APB writes are taken at all times.
// The next request is taken only once the result is loaded. The result sits
// in an output register; while the receiver stalls the next request is still
// accepted and worked on, and its result waits its turn.
module text_console_scrollback_unit
    import tcs_pkg::*;
#(
    parameter int SCREEN_ROWS    = 25,
    parameter int SCREEN_COLUMNS = 80,
    parameter int BUFFER_ROWS    = 64,
    parameter int TAB_WIDTH      = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [7:0] character, [18:8] cell_index, [23:19] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [2:0] kind
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [15:0] cell_value, [26:16] cursor_offset, [32:27] view_line, [39:33] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int STORE_CELLS  = BUFFER_ROWS * SCREEN_COLUMNS;
    localparam int SCREEN_CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int AW  = $clog2(STORE_CELLS);
    localparam int FCW = $clog2(STORE_CELLS + 1);
    localparam int LW  = $clog2(BUFFER_ROWS);
    localparam int CW  = $clog2(SCREEN_COLUMNS);
    localparam int RW  = $clog2(SCREEN_ROWS + 1);
    localparam int SW  = ((LW > RW) ? LW : RW) + 1;
    localparam int PCW = $clog2(((SCREEN_COLUMNS > TAB_WIDTH) ? SCREEN_COLUMNS : TAB_WIDTH) + 1);
    localparam int OFW = LW + CW + 1;

    t_state          r_state, n_state;
    t_state          r_ret, n_ret;
    logic [7:0]      r_text_attr, r_blank_attr;
    logic [7:0]      r_fill_attr, n_fill_attr;
    logic [AW-1:0]   r_fill_addr, n_fill_addr;
    logic [FCW-1:0]  r_fill_cnt, n_fill_cnt;
    logic [AW-1:0]   r_cur_addr, n_cur_addr;
    logic [LW-1:0]   r_cur_line, n_cur_line;
    logic [CW-1:0]   r_cur_col, n_cur_col;
    logic [LW-1:0]   r_base, n_base;
    logic [LW-1:0]   r_view, n_view;
    logic [7:0]      r_char, n_char;
    logic [PCW-1:0]  r_put_cnt, n_put_cnt;
    logic [10:0]     r_rem, n_rem;
    logic [RW-1:0]   r_row, n_row;
    logic [AW-1:0]   r_raddr, n_raddr;
    logic [15:0]     r_rdata;
    logic [15:0]     r_value, n_value;
    logic            r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;

    logic [15:0]     r_cells [STORE_CELLS];

    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [15:0]     w_wdata;

    logic [2:0]      w_kind;
    logic [7:0]      w_char;
    logic [10:0]     w_idx;

    logic            w_ahead;
    logic [LW-1:0]   w_dline;
    logic            w_in_view;
    logic [OFW-1:0]  w_off;

    logic [SW-1:0]   w_line;
    logic [SW-1:0]   w_phys_sum;
    logic [LW-1:0]   w_phys;
    logic [AW-1:0]   w_next_addr;

    assign w_kind = s_axis_tuser;
    assign w_char = s_axis_tdata[7:0];
    assign w_idx  = s_axis_tdata[18:8];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign pready        = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_IDX_TEXT:  prdata = {24'd0, r_text_attr};
            REG_IDX_BLANK: prdata = {24'd0, r_blank_attr};
            default:       prdata = 32'd0;
        endcase
    end

    // The cursor is shown only when it lies strictly after the first view cell
    // and before the end of the view.
    always_comb begin
        w_ahead   = (r_cur_line >= r_view);
        w_dline   = r_cur_line - r_view;
        w_in_view = w_ahead && (SW'(w_dline) < SW'(SCREEN_ROWS))
                    && !((w_dline == '0) && (r_cur_col == '0));
        w_off     = w_in_view ? (OFW'(w_dline) * OFW'(SCREEN_COLUMNS) + OFW'(r_cur_col))
                              : '0;
    end

    // Lines are kept in a ring: logical line L lives in physical row
    // (r_base + L) mod BUFFER_ROWS, so dropping the oldest line is a base step.
    always_comb begin
        w_line     = SW'(r_view) + SW'(r_row);
        w_phys_sum = w_line + SW'(r_base);
        if (w_phys_sum >= SW'(BUFFER_ROWS)) begin
            w_phys = LW'(w_phys_sum - SW'(BUFFER_ROWS));
        end else begin
            w_phys = LW'(w_phys_sum);
        end
        w_next_addr = (r_cur_addr == AW'(STORE_CELLS - 1)) ? '0 : r_cur_addr + 1'b1;
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_fill_attr = r_fill_attr;
        n_fill_addr = r_fill_addr;
        n_fill_cnt  = r_fill_cnt;
        n_cur_addr  = r_cur_addr;
        n_cur_line  = r_cur_line;
        n_cur_col   = r_cur_col;
        n_base      = r_base;
        n_view      = r_view;
        n_char      = r_char;
        n_put_cnt   = r_put_cnt;
        n_rem       = r_rem;
        n_row       = r_row;
        n_raddr     = r_raddr;
        n_value     = r_value;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_we        = 1'b0;
        w_waddr     = r_cur_addr;
        w_wdata     = {r_text_attr, r_char};

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_value = 16'd0;
                    n_state = ST_RESULT;
                    case (t_kind'(w_kind))
                        KIND_PUT: begin
                            n_char = SPACE_CHAR;
                            if (w_char == TAB_CHAR) begin
                                n_put_cnt = PCW'(TAB_WIDTH);
                                n_state   = ST_PUT;
                            end else if (w_char == NL_CHAR) begin
                                n_put_cnt = PCW'(SCREEN_COLUMNS) - PCW'(r_cur_col);
                                n_state   = ST_PUT;
                            end else if (w_char != BS_CHAR && w_char >= SPACE_CHAR) begin
                                n_char    = w_char;
                                n_put_cnt = PCW'(1);
                                n_state   = ST_PUT;
                            end
                        end
                        KIND_UP: begin
                            if (r_view != '0) begin
                                n_view = r_view - 1'b1;
                            end
                        end
                        KIND_DOWN: begin
                            if (r_view != LW'(BUFFER_ROWS - 1)) begin
                                n_view = r_view + 1'b1;
                            end
                        end
                        KIND_CLEAR: begin
                            n_fill_addr = '0;
                            n_fill_cnt  = FCW'(STORE_CELLS);
                            n_fill_attr = r_blank_attr;
                            n_ret       = ST_RESULT;
                            n_cur_addr  = '0;
                            n_cur_line  = '0;
                            n_cur_col   = '0;
                            n_base      = '0;
                            n_view      = '0;
                            n_state     = ST_FILL;
                        end
                        KIND_READ: begin
                            if (32'(w_idx) < SCREEN_CELLS) begin
                                n_rem   = w_idx;
                                n_row   = '0;
                                n_state = ST_DIV;
                            end
                        end
                        default: begin
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_PUT: begin
                w_we       = 1'b1;
                w_waddr    = r_cur_addr;
                w_wdata    = {r_text_attr, r_char};
                n_cur_addr = w_next_addr;
                n_put_cnt  = r_put_cnt - 1'b1;
                if (r_put_cnt == PCW'(1)) begin
                    n_state = ST_RESULT;
                end
                if (r_cur_col == CW'(SCREEN_COLUMNS - 1)) begin
                    n_cur_col = '0;
                    if (r_cur_line == LW'(BUFFER_ROWS - 1)) begin
                        // End of store: the row after the cursor is the oldest
                        // line; it becomes the new, blank last line.
                        n_base      = (r_base == LW'(BUFFER_ROWS - 1)) ? '0 : r_base + 1'b1;
                        n_fill_addr = w_next_addr;
                        n_fill_cnt  = FCW'(SCREEN_COLUMNS);
                        n_fill_attr = r_blank_attr;
                        n_ret       = (r_put_cnt == PCW'(1)) ? ST_RESULT : ST_PUT;
                        n_state     = ST_FILL;
                    end else begin
                        n_cur_line = r_cur_line + 1'b1;
                    end
                end else begin
                    n_cur_col = r_cur_col + 1'b1;
                end
            end
            ST_FILL: begin
                w_we        = 1'b1;
                w_waddr     = r_fill_addr;
                w_wdata     = {r_fill_attr, SPACE_CHAR};
                n_fill_addr = r_fill_addr + 1'b1;
                n_fill_cnt  = r_fill_cnt - 1'b1;
                if (r_fill_cnt == FCW'(1)) begin
                    n_state = r_ret;
                end
            end
            ST_DIV: begin
                // One row per cycle: leaves the row in r_row, the column in r_rem.
                if (r_rem >= 11'(SCREEN_COLUMNS)) begin
                    n_rem = r_rem - 11'(SCREEN_COLUMNS);
                    n_row = r_row + 1'b1;
                end else begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                if (w_line >= SW'(BUFFER_ROWS)) begin
                    n_value = {r_blank_attr, SPACE_CHAR};
                    n_state = ST_RESULT;
                end else begin
                    n_raddr = AW'(w_phys) * AW'(SCREEN_COLUMNS) + AW'(r_rem);
                    n_state = ST_MEM;
                end
            end
            ST_MEM: begin
                n_state = ST_DATA;
            end
            ST_DATA: begin
                n_value = r_rdata;
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'd0, 6'(r_view), 11'(w_off), r_value};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_ret       <= ST_IDLE;
            r_fill_attr <= ATTR_RESET;
            r_fill_addr <= '0;
            r_fill_cnt  <= FCW'(STORE_CELLS);
            r_cur_addr  <= '0;
            r_cur_line  <= '0;
            r_cur_col   <= '0;
            r_base      <= '0;
            r_view      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_fill_attr <= n_fill_attr;
            r_fill_addr <= n_fill_addr;
            r_fill_cnt  <= n_fill_cnt;
            r_cur_addr  <= n_cur_addr;
            r_cur_line  <= n_cur_line;
            r_cur_col   <= n_cur_col;
            r_base      <= n_base;
            r_view      <= n_view;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_put_cnt  <= n_put_cnt;
        r_rem      <= n_rem;
        r_row      <= n_row;
        r_raddr    <= n_raddr;
        r_value    <= n_value;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr  <= ATTR_RESET;
            r_blank_attr <= ATTR_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_IDX_TEXT:  r_text_attr  <= pwdata[7:0];
                REG_IDX_BLANK: r_blank_attr <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_cells[w_waddr] <= w_wdata;
        end
        r_rdata <= r_cells[r_raddr];
    end

endmodule

// ----- hw/rtl/tcs_checker.sv -----
`include "text_console_scrollback_unit_macros.svh"

module tcs_checker
    import tcs_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // The store is swept after reset, so no request may be taken right away.
    `TCS_ASSERT_NEXT(a_busy_after_reset, i_clk, 1'b1, !i_rst_n, !s_axis_tready, "ready right after reset")

    // One request at a time: an accepted request makes the block busy.
    `TCS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready stayed high after a request")

    // A new result only appears while a request is being worked on.
    `TCS_ASSERT_IMP(a_result_from_request, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(!s_axis_tready), "result without a request in progress")

    `TCS_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind text_console_scrollback_unit tcs_checker u_tcs_checker (.*);
